### design/hstsr_pkg.sv
package hstsr_pkg;

	localparam int CW = 42;
	localparam int DW = 19;

	localparam logic [12:0] CLIP_LIMIT = 13'd4096;

	localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [1:0] REG_LINE_COUNT = 2'd1;

	typedef struct packed {
		logic [12:0]               minx;
		logic [12:0]               xlen;
		logic [11:0]               miny;
		logic [12:0]               nrows;
		logic                      clipped;
		logic [7:0]                fill;
		logic [2:0][DW-1:0]        dx;
		logic [2:0][DW-1:0]        dy;
		logic [2:0][CW-1:0]        cy;
		logic [2:0][CW-1:0]        fx;
	} setup_t;

endpackage

### design/half_space_triangle_span_raster.sv
// Channel    Handshake                 Payload
// triangle   start / busy              v1_x v1_y v2_x v2_y v3_x v3_y fill_value
// span       strobe, one cycle         row span_start span_end span_empty
//                                      fill_value_out rows_clipped last_span
// register   cfg_valid / cfg_ready     cfg_index cfg_data
//
// Setup finds the bounding box, then works through each edge in turn, then waits
// for a free slot in a two-entry queue; an empty box ends setup with nothing queued.
// Each span checks each edge in turn, running the shared 13-step restoring divider
// for an edge whose boundary lies inside the box; a triangle gives up to MAX_ROWS spans.
// Reset clears the queue and both sequencers; registers return to 640 by 480.
// Spans cannot be held off; busy drops once setup is queued or the box is empty.
module half_space_triangle_span_raster import hstsr_pkg::*; #(
	parameter int MAX_ROWS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [17:0] v1_x,
	input  logic signed [17:0] v1_y,
	input  logic signed [17:0] v2_x,
	input  logic signed [17:0] v2_y,
	input  logic signed [17:0] v3_x,
	input  logic signed [17:0] v3_y,
	input  logic [7:0]         fill_value,
	output logic               strobe,
	output logic [11:0]        row,
	output logic [12:0]        span_start,
	output logic [12:0]        span_end,
	output logic               span_empty,
	output logic [7:0]         fill_value_out,
	output logic               rows_clipped,
	output logic               last_span,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data
);

	logic [12:0] line_width_q, line_count_q;
	logic        push, pop, full, empty;
	setup_t      push_data, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= 13'd640;
			line_count_q <= 13'd480;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINE_WIDTH: line_width_q <= cfg_data;
				REG_LINE_COUNT: line_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hstsr_front #(.MAX_ROWS(MAX_ROWS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start),
		.v1_x(v1_x), .v1_y(v1_y), .v2_x(v2_x), .v2_y(v2_y), .v3_x(v3_x), .v3_y(v3_y),
		.fill_value(fill_value), .line_width(line_width_q), .line_count(line_count_q),
		.full(full), .busy(busy), .push(push), .push_data(push_data)
	);

	hstsr_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .full(full), .empty(empty), .head(head)
	);

	hstsr_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head), .pop(pop),
		.strobe(strobe), .row(row), .span_start(span_start), .span_end(span_end),
		.span_empty(span_empty), .fill_value_out(fill_value_out),
		.rows_clipped(rows_clipped), .last_span(last_span)
	);

endmodule

### design/hstsr_front.sv
module hstsr_front import hstsr_pkg::*; #(
	parameter int MAX_ROWS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [17:0] v1_x,
	input  logic signed [17:0] v1_y,
	input  logic signed [17:0] v2_x,
	input  logic signed [17:0] v2_y,
	input  logic signed [17:0] v3_x,
	input  logic signed [17:0] v3_y,
	input  logic [7:0]         fill_value,
	input  logic [12:0]        line_width,
	input  logic [12:0]        line_count,
	input  logic               full,
	output logic               busy,
	output logic               push,
	output setup_t             push_data
);

	localparam logic [12:0] MAXR = 13'(MAX_ROWS);

	typedef enum logic [1:0] {F_IDLE, F_BOX, F_EDGE, F_PUSH} fstate_t;

	fstate_t state_q;
	logic signed [17:0]   vx_q [3];
	logic signed [17:0]   vy_q [3];
	logic signed [DW-1:0] dx_q [3];
	logic signed [DW-1:0] dy_q [3];
	logic signed [CW-1:0] cy_q [3];
	logic signed [CW-1:0] fx_q [3];
	logic signed [CW-1:0] m1_q, m2_q, acc_q;
	logic [7:0]  fill_q;
	logic [12:0] minx_q, xlen_q, nrows_q;
	logic [11:0] miny_q;
	logic        clipped_q;
	logic [1:0]  e_q, ph_q;

	function automatic logic signed [14:0] rnd(input logic signed [17:0] v);
		logic signed [18:0] t;
		t = {v[17], v} + 19'sd15;
		return t[18:4];
	endfunction

	logic signed [17:0] lox, hix, loy, hiy;
	logic signed [14:0] rxl, rxh, ryl, ryh;
	logic [12:0] w_c, h_c;
	logic signed [15:0] minx_s, maxx_s, miny_s, maxy_s, xlen_s, ylen_s;
	logic box_empty, clip_c, tl_c;
	logic signed [DW-1:0] dx_c [3];
	logic signed [DW-1:0] dy_c [3];

	always_comb begin
		lox = vx_q[0]; hix = vx_q[0];
		loy = vy_q[0]; hiy = vy_q[0];
		for (int i = 1; i < 3; i++) begin
			if (vx_q[i] < lox) lox = vx_q[i];
			if (vx_q[i] > hix) hix = vx_q[i];
			if (vy_q[i] < loy) loy = vy_q[i];
			if (vy_q[i] > hiy) hiy = vy_q[i];
		end
		rxl = rnd(lox);
		rxh = rnd(hix);
		ryl = rnd(loy);
		ryh = rnd(hiy);
		w_c = (line_width > CLIP_LIMIT) ? CLIP_LIMIT : line_width;
		h_c = (line_count > CLIP_LIMIT) ? CLIP_LIMIT : line_count;
		minx_s = (rxl < 0) ? 16'sd0 : {rxl[14], rxl};
		miny_s = (ryl < 0) ? 16'sd0 : {ryl[14], ryl};
		maxx_s = ($signed({rxh[14], rxh}) > $signed({3'b0, w_c})) ? $signed({3'b0, w_c})
			: {rxh[14], rxh};
		maxy_s = ($signed({ryh[14], ryh}) > $signed({3'b0, h_c})) ? $signed({3'b0, h_c})
			: {ryh[14], ryh};
		xlen_s = maxx_s - minx_s;
		ylen_s = maxy_s - miny_s;
		box_empty = (xlen_s <= 16'sd0) || (ylen_s <= 16'sd0);
		clip_c = ylen_s[12:0] > MAXR;
		for (int i = 0; i < 3; i++) begin
			dx_c[i] = {vx_q[i][17], vx_q[i]} - {vx_q[(i + 1) % 3][17], vx_q[(i + 1) % 3]};
			dy_c[i] = {vy_q[i][17], vy_q[i]} - {vy_q[(i + 1) % 3][17], vy_q[(i + 1) % 3]};
		end
		tl_c = (dy_q[e_q] < 0) || ((dy_q[e_q] == 0) && (dx_q[e_q] > 0));
	end

	assign busy = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !full;

	always_comb begin
		push_data.minx    = minx_q;
		push_data.xlen    = xlen_q;
		push_data.miny    = miny_q;
		push_data.nrows   = nrows_q;
		push_data.clipped = clipped_q;
		push_data.fill    = fill_q;
		for (int i = 0; i < 3; i++) begin
			push_data.dx[i] = dx_q[i];
			push_data.dy[i] = dy_q[i];
			push_data.cy[i] = cy_q[i];
			push_data.fx[i] = fx_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			e_q     <= 2'd0;
			ph_q    <= 2'd0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						vx_q[0] <= v1_x; vy_q[0] <= v1_y;
						vx_q[1] <= v2_x; vy_q[1] <= v2_y;
						vx_q[2] <= v3_x; vy_q[2] <= v3_y;
						fill_q  <= fill_value;
						state_q <= F_BOX;
					end
				end
				F_BOX: begin
					minx_q    <= minx_s[12:0];
					xlen_q    <= xlen_s[12:0];
					miny_q    <= miny_s[11:0];
					clipped_q <= clip_c;
					nrows_q   <= clip_c ? MAXR : ylen_s[12:0];
					for (int i = 0; i < 3; i++) begin
						dx_q[i] <= dx_c[i];
						dy_q[i] <= dy_c[i];
					end
					e_q     <= 2'd0;
					ph_q    <= 2'd0;
					state_q <= box_empty ? F_IDLE : F_EDGE;
				end
				F_EDGE: begin
					ph_q <= ph_q + 2'd1;
					unique case (ph_q)
						2'd0: begin
							m1_q <= dy_q[e_q] * vx_q[e_q];
							m2_q <= dx_q[e_q] * vy_q[e_q];
						end
						2'd1: begin
							acc_q <= m1_q - m2_q + $signed({{(CW-1){1'b0}}, tl_c});
							m1_q  <= dx_q[e_q] * $signed({1'b0, miny_q});
							m2_q  <= dy_q[e_q] * $signed({1'b0, minx_q});
						end
						2'd2: begin
							cy_q[e_q] <= acc_q + ((m1_q - m2_q) <<< 4);
							m1_q      <= dy_q[e_q] * $signed({1'b0, xlen_q});
						end
						default: begin
							fx_q[e_q] <= m1_q <<< 4;
							if (e_q == 2'd2) state_q <= F_PUSH;
							else e_q <= e_q + 2'd1;
						end
					endcase
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

### design/hstsr_fifo.sv
module hstsr_fifo import hstsr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  setup_t push_data,
	input  logic   pop,
	output logic   full,
	output logic   empty,
	output setup_t head
);

	setup_t     mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

### design/hstsr_back.sv
module hstsr_back import hstsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  setup_t      head,
	output logic        pop,
	output logic        strobe,
	output logic [11:0] row,
	output logic [12:0] span_start,
	output logic [12:0] span_end,
	output logic        span_empty,
	output logic [7:0]  fill_value_out,
	output logic        rows_clipped,
	output logic        last_span
);

	typedef enum logic [2:0] {B_IDLE, B_EDGE, B_PREP, B_DIV, B_APPLY, B_EMIT} bstate_t;

	bstate_t state_q;
	setup_t  rec_q;
	logic signed [CW-1:0] cy_q [3];
	logic signed [CW-1:0] nsig_q;
	logic [CW-1:0] rem_q;
	logic [22:0]   den_q;
	logic [12:0]   q_q, s_q, t_q, row_q;
	logic [3:0]    bit_q;
	logic [1:0]    e_q;
	logic          div_a_q;

	logic signed [CW-1:0] cx, cxe, fdy, stp, absf;
	logic cx_pos, cxe_pos, need_a, need_b;
	logic [12:0] a_imm, b_imm;
	logic [CW-1:0] trial;

	always_comb begin
		cx      = cy_q[e_q];
		fdy     = CW'($signed(rec_q.dy[e_q])) <<< 4;
		cxe     = cx - $signed(rec_q.fx[e_q]);
		stp     = (fdy > 0) ? fdy - 1 : fdy + 1;
		absf    = (fdy < 0) ? -fdy : fdy;
		cx_pos  = cx > 0;
		cxe_pos = cxe > 0;
		need_a  = !cx_pos && cxe_pos && (fdy != 0);
		need_b  = cx_pos && !cxe_pos && (fdy != 0);
		a_imm   = (!cx_pos && !cxe_pos) ? rec_q.xlen : 13'd0;
		b_imm   = cxe_pos ? rec_q.xlen : 13'd0;
		trial   = {{(CW-23){1'b0}}, den_q} << bit_q;
	end

	assign pop = (state_q == B_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			strobe  <= 1'b0;
			e_q     <= 2'd0;
			row_q   <= 13'd0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						rec_q <= head;
						for (int i = 0; i < 3; i++) cy_q[i] <= $signed(head.cy[i]);
						row_q   <= 13'd0;
						e_q     <= 2'd0;
						s_q     <= 13'd0;
						t_q     <= head.xlen;
						state_q <= B_EDGE;
					end
				end
				B_EDGE: begin
					if (!need_a && a_imm > s_q) s_q <= a_imm;
					if (!need_b && b_imm < t_q) t_q <= b_imm;
					nsig_q  <= cx + stp;
					den_q   <= absf[22:0];
					div_a_q <= need_a;
					if (need_a || need_b) state_q <= B_PREP;
					else if (e_q == 2'd2) state_q <= B_EMIT;
					else e_q <= e_q + 2'd1;
				end
				B_PREP: begin
					rem_q   <= (nsig_q < 0) ? -nsig_q : nsig_q;
					q_q     <= 13'd0;
					bit_q   <= 4'd12;
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (rem_q >= trial) begin
						rem_q        <= rem_q - trial;
						q_q[bit_q]   <= 1'b1;
					end
					if (bit_q == 4'd0) state_q <= B_APPLY;
					else bit_q <= bit_q - 4'd1;
				end
				B_APPLY: begin
					if (div_a_q) begin
						if (q_q > s_q) s_q <= q_q;
					end else begin
						if (q_q < t_q) t_q <= q_q;
					end
					if (e_q == 2'd2) state_q <= B_EMIT;
					else begin
						e_q     <= e_q + 2'd1;
						state_q <= B_EDGE;
					end
				end
				B_EMIT: begin
					strobe         <= 1'b1;
					row            <= rec_q.miny + row_q[11:0];
					span_start     <= rec_q.minx + s_q;
					span_end       <= rec_q.minx + t_q;
					span_empty     <= (s_q >= t_q);
					fill_value_out <= rec_q.fill;
					rows_clipped   <= rec_q.clipped;
					last_span      <= (row_q == rec_q.nrows - 13'd1);
					for (int i = 0; i < 3; i++)
						cy_q[i] <= cy_q[i] + (CW'($signed(rec_q.dx[i])) <<< 4);
					if (row_q == rec_q.nrows - 13'd1) state_q <= B_IDLE;
					else begin
						row_q   <= row_q + 13'd1;
						e_q     <= 2'd0;
						s_q     <= 13'd0;
						t_q     <= rec_q.xlen;
						state_q <= B_EDGE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
